// ===== hdl/mtfw_pkg.sv =====
// Package for the mutex table unit: sizes, opcodes, status codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package mtfw_pkg;
  localparam int NUM_SLOTS   = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QPOS_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QADDR_W = SLOT_W + QPOS_W;
  localparam int QWORDS  = NUM_SLOTS * QUEUE_DEPTH;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_LOCK    = 3'd2;
  localparam logic [2:0] OP_TRYLOCK = 3'd3;
  localparam logic [2:0] OP_UNLOCK  = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_BUSY       = 3'd2;
  localparam logic [2:0] ST_NO_SLOT    = 3'd3;
  localparam logic [2:0] ST_QUEUED     = 3'd4;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item and look up the table
    logic exec;      // apply the command to the slot and build a result
    logic pop;       // destroy: pop the next waiter and build a result
    logic rd_head;   // issue the read of the head waiter
  } mtfw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_head; // command needs the head waiter read first
    logic drain;     // destroy of a slot with waiters
    logic more;      // waiters remain after the current pop
  } mtfw_stat_t;
endpackage

// ===== hdl/mtfw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mtfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/mtfw_dp.sv =====
// Datapath of the mutex table: slot registers, id counter, waiter queues
// (circular, one RAM region per slot) and result register. Uses mtfw_pkg.
`timescale 1ns / 1ps
module mtfw_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mtfw_pkg::mtfw_cmd_t    cmd,
  output mtfw_pkg::mtfw_stat_t   stat,
  input  logic [2:0]             in_opcode,
  input  logic [31:0]            in_mutex_id,
  input  logic [15:0]            in_requester_pid,
  output logic [2:0]             out_status,
  output logic [31:0]            out_assigned_id,
  output logic                   out_wake_valid,
  output logic [15:0]            out_woken_pid,
  output logic                   out_is_locked,
  output logic [15:0]            out_owner,
  output logic [3:0]             out_waiting,
  output logic [31:0]            out_grants,
  output logic [31:0]            out_contentions,
  output logic                   out_last
);
  localparam int SW = mtfw_pkg::SLOT_W;
  localparam int QW = mtfw_pkg::QPOS_W;
  localparam int CW = mtfw_pkg::CNT_W;
  localparam int NS = mtfw_pkg::NUM_SLOTS;
  localparam int QD = mtfw_pkg::QUEUE_DEPTH;

  logic [NS-1:0] act_r;
  logic [31:0]   id_r    [NS];
  logic [NS-1:0] lck_r;
  logic [15:0]   own_r   [NS];
  logic [CW-1:0] cnt_r   [NS];
  logic [QW-1:0] head_r  [NS];
  logic [31:0]   gr_r    [NS];
  logic [31:0]   ct_r    [NS];
  logic [31:0]   next_id_r;

  logic [2:0]    op_r;
  logic [31:0]   mid_r;
  logic [15:0]   pid_r;
  logic [SW-1:0] sl_r;
  logic          hit_r;
  logic          free_ok_r;

  // Qualifier per slot and the lowest-index picks for lookup and create.
  logic [SW-1:0] hit_idx, free_idx;
  logic          hit_any, free_any;
  always_comb begin
    hit_idx = '0; hit_any = 1'b0; free_idx = '0; free_any = 1'b0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (act_r[i] && id_r[i] == in_mutex_id) begin
        hit_idx = SW'(i); hit_any = 1'b1;
      end
      if (!act_r[i]) begin
        free_idx = SW'(i); free_any = 1'b1;
      end
    end
  end

  // Queue RAM: a slot's waiters live at slot*QD + position.
  logic                        q_we;
  logic [mtfw_pkg::QADDR_W-1:0] q_waddr, q_raddr;
  logic [15:0]                 q_rdata;
  logic [QW-1:0]               tail_pos;
  logic [CW+QW:0]              tail_sum;

  always_comb begin
    tail_sum = (CW+QW+1)'(head_r[sl_r]) + (CW+QW+1)'(cnt_r[sl_r]);
    if (tail_sum >= (CW+QW+1)'(QD)) tail_sum = tail_sum - (CW+QW+1)'(QD);
    tail_pos = tail_sum[QW-1:0];
  end

  assign q_raddr = mtfw_pkg::QADDR_W'(sl_r) * mtfw_pkg::QADDR_W'(QD)
                 + mtfw_pkg::QADDR_W'(head_r[sl_r]);
  assign q_waddr = mtfw_pkg::QADDR_W'(sl_r) * mtfw_pkg::QADDR_W'(QD)
                 + mtfw_pkg::QADDR_W'(tail_pos);

  logic lk_held, lk_queue;
  assign lk_held  = lck_r[sl_r];
  assign lk_queue = hit_r && op_r == mtfw_pkg::OP_LOCK && lk_held && pid_r != '0
                  && cnt_r[sl_r] < CW'(QD);
  assign q_we = cmd.exec && lk_queue;

  mtfw_ram #(.WIDTH(16), .DEPTH(mtfw_pkg::QWORDS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(pid_r),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // Status for the controller.
  assign stat.need_head = hit_r && cnt_r[sl_r] != '0
                        && (op_r == mtfw_pkg::OP_UNLOCK || op_r == mtfw_pkg::OP_DESTROY);
  assign stat.drain     = hit_r && op_r == mtfw_pkg::OP_DESTROY && cnt_r[sl_r] != '0;
  assign stat.more      = cnt_r[sl_r] > CW'(1);

  function automatic logic [QW-1:0] inc_pos(input logic [QW-1:0] p);
    return (p == QW'(QD - 1)) ? '0 : p + QW'(1);
  endfunction

  // Capture of the item and of the lookup result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      mid_r     <= in_mutex_id;
      pid_r     <= in_requester_pid;
      hit_r     <= hit_any && in_opcode != mtfw_pkg::OP_CREATE
                   && in_opcode <= mtfw_pkg::OP_QUERY;
      free_ok_r <= free_any;
      sl_r      <= (in_opcode == mtfw_pkg::OP_CREATE) ? free_idx : hit_idx;
    end
  end

  // Slot state update and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= '0;
      lck_r     <= '0;
      next_id_r <= 32'd1;
      for (int i = 0; i < NS; i++) begin
        id_r[i] <= '0; own_r[i] <= '0; cnt_r[i] <= '0; head_r[i] <= '0;
        gr_r[i] <= '0; ct_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      out_wake_valid <= 1'b0;
      out_woken_pid  <= '0;
      out_last       <= 1'b1;
      out_assigned_id <= mid_r;
      out_is_locked  <= lck_r[sl_r];
      out_owner      <= own_r[sl_r];
      out_waiting    <= 4'(cnt_r[sl_r]);
      out_grants     <= gr_r[sl_r];
      out_contentions <= ct_r[sl_r];
      out_status     <= mtfw_pkg::ST_OK;
      if (op_r == mtfw_pkg::OP_CREATE) begin
        if (!free_ok_r) begin
          out_status <= mtfw_pkg::ST_NO_SLOT;
          out_assigned_id <= '0;
          out_is_locked <= 1'b0; out_owner <= '0; out_waiting <= '0;
          out_grants <= '0; out_contentions <= '0;
        end else begin
          act_r[sl_r] <= 1'b1; id_r[sl_r] <= next_id_r;
          next_id_r <= next_id_r + 32'd1;
          lck_r[sl_r] <= 1'b0; own_r[sl_r] <= '0; cnt_r[sl_r] <= '0;
          gr_r[sl_r] <= '0; ct_r[sl_r] <= '0;
          out_assigned_id <= next_id_r;
          out_is_locked <= 1'b0; out_owner <= '0; out_waiting <= '0;
          out_grants <= '0; out_contentions <= '0;
        end
      end else if (!hit_r) begin
        out_status <= mtfw_pkg::ST_NOT_FOUND;
        out_is_locked <= 1'b0; out_owner <= '0; out_waiting <= '0;
        out_grants <= '0; out_contentions <= '0;
      end else begin
        unique case (op_r)
          mtfw_pkg::OP_DESTROY: begin
            act_r[sl_r] <= 1'b0; id_r[sl_r] <= '0;
          end
          mtfw_pkg::OP_LOCK, mtfw_pkg::OP_TRYLOCK: begin
            if (!lk_held) begin
              lck_r[sl_r] <= 1'b1; own_r[sl_r] <= pid_r;
              gr_r[sl_r] <= gr_r[sl_r] + 32'd1;
              out_is_locked <= 1'b1; out_owner <= pid_r;
              out_grants <= gr_r[sl_r] + 32'd1;
            end else if (op_r == mtfw_pkg::OP_TRYLOCK) begin
              out_status <= mtfw_pkg::ST_BUSY;
            end else begin
              ct_r[sl_r] <= ct_r[sl_r] + 32'd1;
              out_contentions <= ct_r[sl_r] + 32'd1;
              if (pid_r == '0) out_status <= mtfw_pkg::ST_BUSY;
              else if (!lk_queue) out_status <= mtfw_pkg::ST_QUEUE_FULL;
              else begin
                cnt_r[sl_r] <= cnt_r[sl_r] + CW'(1);
                out_waiting <= 4'(cnt_r[sl_r] + CW'(1));
                out_status <= mtfw_pkg::ST_QUEUED;
              end
            end
          end
          mtfw_pkg::OP_UNLOCK: begin
            if (cnt_r[sl_r] != '0) begin
              cnt_r[sl_r] <= cnt_r[sl_r] - CW'(1);
              head_r[sl_r] <= inc_pos(head_r[sl_r]);
              lck_r[sl_r] <= 1'b1; own_r[sl_r] <= q_rdata;
              gr_r[sl_r] <= gr_r[sl_r] + 32'd1;
              out_wake_valid <= 1'b1; out_woken_pid <= q_rdata;
              out_is_locked <= 1'b1; out_owner <= q_rdata;
              out_waiting <= 4'(cnt_r[sl_r] - CW'(1));
              out_grants <= gr_r[sl_r] + 32'd1;
            end else begin
              lck_r[sl_r] <= 1'b0; own_r[sl_r] <= '0;
              out_is_locked <= 1'b0; out_owner <= '0;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd.pop) begin
      // One destroy wake: head waiter out, count down, slot retired.
      act_r[sl_r]  <= 1'b0;
      id_r[sl_r]   <= '0;
      cnt_r[sl_r]  <= cnt_r[sl_r] - CW'(1);
      head_r[sl_r] <= inc_pos(head_r[sl_r]);
      out_status <= mtfw_pkg::ST_OK;
      out_assigned_id <= mid_r;
      out_wake_valid <= 1'b1; out_woken_pid <= q_rdata;
      out_is_locked <= lck_r[sl_r]; out_owner <= own_r[sl_r];
      out_waiting <= 4'(cnt_r[sl_r] - CW'(1));
      out_grants <= gr_r[sl_r]; out_contentions <= ct_r[sl_r];
      out_last <= !stat.more;
    end
  end
endmodule

// ===== hdl/mtfw_ctrl.sv =====
// Controller of the mutex table: sequences lookup, queue read, update and
// destroy drain, and owns the handshakes. Uses mtfw_pkg.
`timescale 1ns / 1ps
module mtfw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mtfw_pkg::mtfw_stat_t stat,
  output mtfw_pkg::mtfw_cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_HEAD, S_EXEC, S_DRAIN, S_PHEAD, S_POP}
    state_t;
  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    cmd.load    = in_valid && in_ready;
    cmd.rd_head = state_r == S_HEAD || state_r == S_PHEAD;
    cmd.exec    = state_r == S_EXEC && out_free;
    cmd.pop     = state_r == S_POP && out_free;
  end

  // State and output valid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_LOOK;
        S_LOOK:  state_r <= stat.need_head ? S_HEAD : S_EXEC;
        S_HEAD:  state_r <= S_EXEC;
        S_EXEC:  if (out_free) begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_DRAIN: state_r <= S_PHEAD;
        S_PHEAD: state_r <= S_POP;
        S_POP:   if (out_free) begin
          out_valid_r <= 1'b1;
          state_r <= stat.more ? S_PHEAD : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // A destroy with waiters drains instead of a single result.
      if (state_r == S_LOOK && stat.drain) state_r <= S_DRAIN;
    end
  end
endmodule

// ===== hdl/mutex_table_fifo_waiters_top.sv =====
// Top level of the mutex table unit: controller plus datapath.
// Depends on mtfw_pkg, mtfw_ctrl, mtfw_dp and mtfw_ram.
`timescale 1ns / 1ps
// A mutex table of 16 slots with FIFO waiter queues of 8 entries each. One
// command is taken at a time; a command passes through lookup and update
// before its result, with a read of the head waiter from the queue RAM in
// between for unlock with waiters. Destroy of a slot with n waiters gives
// n results, each paced by the registered queue RAM read.
// The table resets at once; the queue memory needs no clearing.
module mutex_table_fifo_waiters_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_mutex_id,
  input  logic [15:0] in_requester_pid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_assigned_id,
  output logic        out_wake_valid,
  output logic [15:0] out_woken_pid,
  output logic        out_is_locked,
  output logic [15:0] out_owner,
  output logic [3:0]  out_waiting,
  output logic [31:0] out_grants,
  output logic [31:0] out_contentions,
  output logic        out_last
);
  mtfw_pkg::mtfw_cmd_t  cmd;
  mtfw_pkg::mtfw_stat_t stat;

  mtfw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  mtfw_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_opcode(in_opcode), .in_mutex_id(in_mutex_id),
    .in_requester_pid(in_requester_pid),
    .out_status(out_status), .out_assigned_id(out_assigned_id),
    .out_wake_valid(out_wake_valid), .out_woken_pid(out_woken_pid),
    .out_is_locked(out_is_locked), .out_owner(out_owner),
    .out_waiting(out_waiting), .out_grants(out_grants),
    .out_contentions(out_contentions), .out_last(out_last)
  );
endmodule

// ===== hdl/mtfw_checker.sv =====
// Port-level checks of the mutex table unit, bound to the top level.
// Depends on mtfw_pkg and mutex_table_fifo_waiters_top.
`timescale 1ns / 1ps
module mtfw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_wake_valid,
  input logic [15:0] out_woken_pid,
  input logic        out_last
);
  // A stalled result item holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_woken_pid))
    else $error("result changed while stalled");
  // Only one command is in flight: an accepted item closes the input.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");
  // A wake always reports ok.
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_valid |-> out_status == mtfw_pkg::ST_OK)
    else $error("wake with non-ok status");
  // Non-final results only come from destroy wakes.
  a_multi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_wake_valid)
    else $error("non-final result without a wake");
endmodule

bind mutex_table_fifo_waiters_top mtfw_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_wake_valid(out_wake_valid), .out_woken_pid(out_woken_pid),
  .out_last(out_last)
);

// ===== tb/tb_mutex_table_fifo_waiters_top.sv =====
// Testbench for the mutex table unit with FIFO waiter queues.
// Holds its own table predictor, sends commands with random idling and checks each result.
// Depends on mtfw_pkg and mutex_table_fifo_waiters_top.
`timescale 1ns / 1ps
module tb_mutex_table_fifo_waiters_top;
  localparam int WATCHDOG_LIMIT = 5000;

  // One expected result item.
  typedef struct {
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic        wake_valid;
    logic [15:0] woken_pid;
    logic        is_locked;
    logic [15:0] owner;
    logic [3:0]  waiting;
    logic [31:0] grants;
    logic [31:0] contentions;
    logic        last;
  } mutex_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode = '0;
  logic [31:0] in_mutex_id = '0;
  logic [15:0] in_requester_pid = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_assigned_id;
  logic        out_wake_valid;
  logic [15:0] out_woken_pid;
  logic        out_is_locked;
  logic [15:0] out_owner;
  logic [3:0]  out_waiting;
  logic [31:0] out_grants;
  logic [31:0] out_contentions;
  logic        out_last;

  mutex_table_fifo_waiters_top dut (.*);

  always #5 clk = ~clk;

  // Predictor state: a copy of the mutex table.
  logic        tbl_active [mtfw_pkg::NUM_SLOTS];
  logic [31:0] tbl_id [mtfw_pkg::NUM_SLOTS];
  logic        tbl_locked [mtfw_pkg::NUM_SLOTS];
  logic [15:0] tbl_owner [mtfw_pkg::NUM_SLOTS];
  logic [15:0] tbl_waiters [mtfw_pkg::NUM_SLOTS][$];
  logic [31:0] tbl_grants [mtfw_pkg::NUM_SLOTS];
  logic [31:0] tbl_contentions [mtfw_pkg::NUM_SLOTS];
  logic [31:0] id_counter;

  mutex_result_t pending_results[$];
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  recv_hold = 0;
  int  quiet_cycles = 0;
  // Ids handed out so far, so that random commands mostly address live mutexes.
  logic [31:0] known_ids[$];

  // Builds one expected result; slot < 0 gives zero slot fields.
  function automatic mutex_result_t make_result(logic [2:0] st, logic [31:0] id,
                                                logic wv, logic [15:0] wpid,
                                                int slot, logic lst);
    mutex_result_t r;
    r.status = st;
    r.assigned_id = id;
    r.wake_valid = wv;
    r.woken_pid = wpid;
    r.last = lst;
    if (slot >= 0) begin
      r.is_locked = tbl_locked[slot];
      r.owner = tbl_owner[slot];
      r.waiting = 4'(tbl_waiters[slot].size());
      r.grants = tbl_grants[slot];
      r.contentions = tbl_contentions[slot];
    end else begin
      r.is_locked = 1'b0;
      r.owner = '0;
      r.waiting = '0;
      r.grants = '0;
      r.contentions = '0;
    end
    return r;
  endfunction

  // Applies one command to the table copy and queues the results it causes.
  task automatic predict_mutex_op(logic [2:0] op, logic [31:0] id, logic [15:0] pid);
    int slot;
    logic [15:0] w;
    slot = -1;
    if (op == mtfw_pkg::OP_CREATE) begin
      for (int i = mtfw_pkg::NUM_SLOTS - 1; i >= 0; i--)
        if (!tbl_active[i]) slot = i;
      if (slot < 0) begin
        pending_results.push_back(make_result(mtfw_pkg::ST_NO_SLOT, '0, 1'b0, '0, -1, 1'b1));
      end else begin
        tbl_active[slot] = 1'b1;
        tbl_id[slot] = id_counter;
        id_counter = id_counter + 1;
        tbl_locked[slot] = 1'b0;
        tbl_owner[slot] = '0;
        tbl_waiters[slot].delete();
        tbl_grants[slot] = '0;
        tbl_contentions[slot] = '0;
        known_ids.push_back(tbl_id[slot]);
        pending_results.push_back(make_result(mtfw_pkg::ST_OK, tbl_id[slot], 1'b0, '0,
                                              slot, 1'b1));
      end
      return;
    end
    for (int i = mtfw_pkg::NUM_SLOTS - 1; i >= 0; i--)
      if (tbl_active[i] && tbl_id[i] == id) slot = i;
    if (op > mtfw_pkg::OP_QUERY || slot < 0) begin
      pending_results.push_back(make_result(mtfw_pkg::ST_NOT_FOUND, id, 1'b0, '0, -1, 1'b1));
      return;
    end
    case (op)
      mtfw_pkg::OP_DESTROY: begin
        tbl_active[slot] = 1'b0;
        tbl_id[slot] = '0;
        if (tbl_waiters[slot].size() == 0)
          pending_results.push_back(make_result(mtfw_pkg::ST_OK, id, 1'b0, '0, slot, 1'b1));
        while (tbl_waiters[slot].size() > 0) begin
          w = tbl_waiters[slot].pop_front();
          pending_results.push_back(make_result(mtfw_pkg::ST_OK, id, 1'b1, w, slot,
                                                tbl_waiters[slot].size() == 0));
        end
      end
      mtfw_pkg::OP_LOCK: begin
        if (!tbl_locked[slot]) begin
          tbl_locked[slot] = 1'b1;
          tbl_owner[slot] = pid;
          tbl_grants[slot] = tbl_grants[slot] + 1;
          pending_results.push_back(make_result(mtfw_pkg::ST_OK, id, 1'b0, '0, slot, 1'b1));
        end else begin
          tbl_contentions[slot] = tbl_contentions[slot] + 1;
          if (pid == 0) begin
            pending_results.push_back(make_result(mtfw_pkg::ST_BUSY, id, 1'b0, '0,
                                                  slot, 1'b1));
          end else if (tbl_waiters[slot].size() >= mtfw_pkg::QUEUE_DEPTH) begin
            pending_results.push_back(make_result(mtfw_pkg::ST_QUEUE_FULL, id, 1'b0, '0,
                                                  slot, 1'b1));
          end else begin
            tbl_waiters[slot].push_back(pid);
            pending_results.push_back(make_result(mtfw_pkg::ST_QUEUED, id, 1'b0, '0,
                                                  slot, 1'b1));
          end
        end
      end
      mtfw_pkg::OP_TRYLOCK: begin
        if (tbl_locked[slot]) begin
          pending_results.push_back(make_result(mtfw_pkg::ST_BUSY, id, 1'b0, '0, slot, 1'b1));
        end else begin
          tbl_locked[slot] = 1'b1;
          tbl_owner[slot] = pid;
          tbl_grants[slot] = tbl_grants[slot] + 1;
          pending_results.push_back(make_result(mtfw_pkg::ST_OK, id, 1'b0, '0, slot, 1'b1));
        end
      end
      mtfw_pkg::OP_UNLOCK: begin
        if (tbl_waiters[slot].size() > 0) begin
          w = tbl_waiters[slot].pop_front();
          tbl_locked[slot] = 1'b1;
          tbl_owner[slot] = w;
          tbl_grants[slot] = tbl_grants[slot] + 1;
          pending_results.push_back(make_result(mtfw_pkg::ST_OK, id, 1'b1, w, slot, 1'b1));
        end else begin
          tbl_locked[slot] = 1'b0;
          tbl_owner[slot] = '0;
          pending_results.push_back(make_result(mtfw_pkg::ST_OK, id, 1'b0, '0, slot, 1'b1));
        end
      end
      default: begin
        pending_results.push_back(make_result(mtfw_pkg::ST_OK, id, 1'b0, '0, slot, 1'b1));
      end
    endcase
  endtask

  // Sends one item, idling beforehand at random, and predicts on acceptance.
  // Valid stays high after acceptance until the next item or an idle cycle.
  task automatic send_item(logic [2:0] op, logic [31:0] id, logic [15:0] pid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_mutex_id <= id;
    in_requester_pid <= pid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_mutex_op(op, id, pid);
  endtask

  function automatic logic [31:0] pick_id();
    if (known_ids.size() == 0 || $urandom_range(9) == 0) return $urandom();
    return known_ids[$urandom_range(known_ids.size() - 1)];
  endfunction

  function automatic logic [15:0] pick_pid();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // Receiver: random stalls, optionally a long hold-off.
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    mutex_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, status %0d", $time, out_status);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if ({out_status, out_assigned_id, out_wake_valid, out_woken_pid, out_is_locked,
             out_owner, out_waiting, out_grants, out_contentions, out_last} !==
            {e.status, e.assigned_id, e.wake_valid, e.woken_pid, e.is_locked,
             e.owner, e.waiting, e.grants, e.contentions, e.last}) begin
          $display({"%0t: mismatch expected st=%0d id=%h wv=%b wp=%h lk=%b own=%h",
                    " wt=%0d g=%0d c=%0d l=%b"},
                   $time, e.status, e.assigned_id, e.wake_valid, e.woken_pid, e.is_locked,
                   e.owner, e.waiting, e.grants, e.contentions, e.last);
          $display({"%0t: mismatch actual   st=%0d id=%h wv=%b wp=%h lk=%b own=%h",
                    " wt=%0d g=%0d c=%0d l=%b"},
                   $time, out_status, out_assigned_id, out_wake_valid, out_woken_pid,
                   out_is_locked, out_owner, out_waiting, out_grants, out_contentions,
                   out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Directed: extremes, every opcode, unknown ids, full queue, drains.
  task automatic test_directed();
    logic [31:0] id;
    send_item(mtfw_pkg::OP_QUERY, 32'hffffffff, 16'hffff);
    send_item(3'd6, 32'h0, 16'h0);
    send_item(3'd7, 32'hffffffff, 16'hffff);
    send_item(mtfw_pkg::OP_CREATE, 32'hdeadbeef, 16'h0);
    id = known_ids[0];
    send_item(mtfw_pkg::OP_LOCK, id, 16'hffff);
    send_item(mtfw_pkg::OP_LOCK, id, 16'h0);
    send_item(mtfw_pkg::OP_TRYLOCK, id, 16'h5);
    for (int i = 0; i < mtfw_pkg::QUEUE_DEPTH + 1; i++)
      send_item(mtfw_pkg::OP_LOCK, id, 16'(i + 1));
    send_item(mtfw_pkg::OP_UNLOCK, id, 16'h7);
    send_item(mtfw_pkg::OP_DESTROY, id, 16'h0);
    send_item(mtfw_pkg::OP_UNLOCK, id, 16'h0);
    send_item(mtfw_pkg::OP_CREATE, 32'h0, 16'h0);
    send_item(mtfw_pkg::OP_UNLOCK, known_ids[1], 16'h0);
    send_item(mtfw_pkg::OP_TRYLOCK, known_ids[1], 16'h0);
    send_item(mtfw_pkg::OP_DESTROY, known_ids[1], 16'h1);
  endtask

  // Fills the table until create reports no slot.
  task automatic test_table_full();
    for (int i = 0; i < mtfw_pkg::NUM_SLOTS + 1; i++)
      send_item(mtfw_pkg::OP_CREATE, $urandom(), 16'h0);
  endtask

  // Random commands on live mutexes, with occasional noise.
  task automatic test_random(int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0: op = mtfw_pkg::OP_CREATE;
        1: op = mtfw_pkg::OP_DESTROY;
        2: op = 3'($urandom_range(6, 7));
        3, 4, 5, 6, 7, 8, 9: op = mtfw_pkg::OP_LOCK;
        10, 11: op = mtfw_pkg::OP_TRYLOCK;
        12, 13, 14, 15, 16: op = mtfw_pkg::OP_UNLOCK;
        default: op = mtfw_pkg::OP_QUERY;
      endcase
      send_item(op, pick_id(), pick_pid());
    end
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_backpressure();
    recv_hold = 200;
    test_random(12);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < mtfw_pkg::NUM_SLOTS; i++) begin
      tbl_active[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_locked[i] = 1'b0;
      tbl_owner[i] = '0;
      tbl_grants[i] = '0;
      tbl_contentions[i] = '0;
    end
    id_counter = 32'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 87;
    test_directed();
    test_table_full();
    test_random(30);
    send_idle_pct = 87;
    recv_idle_pct = 20;
    test_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(20);
    wait_drained();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/mtfw_pkg.sv
hdl/mtfw_ram.sv
hdl/mtfw_dp.sv
hdl/mtfw_ctrl.sv
hdl/mutex_table_fifo_waiters_top.sv
hdl/mtfw_checker.sv
tb/tb_mutex_table_fifo_waiters_top.sv
